FILE: rtl/core/decimal_value_to_ascii_macros.svh
// Assertion macros for the decimal value to ASCII formatter.
`ifndef DECIMAL_VALUE_TO_ASCII_MACROS_SVH
`define DECIMAL_VALUE_TO_ASCII_MACROS_SVH

`ifndef SYNTHESIS
`define DVA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DVA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DVA_ASSERT_SAME(label, ante, cons)
`define DVA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/core/dva_pkg.sv
// Shared constants and controller/datapath interface types for the formatter.
`default_nettype none
package dva_pkg;
    localparam int NUM_DIGITS = 29;
    localparam int BCD_BITS   = NUM_DIGITS * 4;
    localparam int POS_W      = 5;
    localparam int IN_BITS    = 96;
    localparam int CHAR_W     = 7;
    localparam int SCALE_W    = 8;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 7'd46;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

    localparam logic [1:0] SEL_DIGIT = 2'd0;
    localparam logic [1:0] SEL_MINUS = 2'd1;
    localparam logic [1:0] SEL_POINT = 2'd2;

    typedef struct packed {
        logic       load;
        logic       conv;
        logic       shift;
        logic       emit;
        logic [1:0] sel;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic top_zero;
    } t_sts;
endpackage
`default_nettype wire

FILE: rtl/core/dva_datapath.sv
// Datapath: mantissa shifter, BCD digit register and output character register.
`default_nettype none
module dva_datapath #(
    parameter int MANTISSA_BITS = 96
) (
    input  wire logic                        i_clk,
    input  wire dva_pkg::t_cmd               i_cmd,
    input  wire logic [dva_pkg::IN_BITS-1:0] i_mantissa,
    output dva_pkg::t_sts                    o_sts,
    output logic [dva_pkg::CHAR_W-1:0]       o_char_code,
    output logic                             o_last
);
    logic [MANTISSA_BITS-1:0]      r_mant;
    logic [MANTISSA_BITS-1:0]      n_mant;
    logic [dva_pkg::BCD_BITS-1:0]  r_bcd;
    logic [dva_pkg::BCD_BITS-1:0]  n_bcd;
    logic [dva_pkg::BCD_BITS-1:0]  adj;
    logic [dva_pkg::CHAR_W-1:0]    r_char;
    logic [dva_pkg::CHAR_W-1:0]    n_char;
    logic                          r_last;
    logic [3:0]                    top;

    assign top = r_bcd[dva_pkg::BCD_BITS-1 -: 4];
    assign o_sts.top_zero = (top == 4'd0);

    always_comb begin
        for (int d = 0; d < dva_pkg::NUM_DIGITS; d++) begin
            adj[d*4 +: 4] = (r_bcd[d*4 +: 4] >= 4'd5) ? r_bcd[d*4 +: 4] + 4'd3
                                                       : r_bcd[d*4 +: 4];
        end
    end

    always_comb begin
        n_mant = r_mant;
        n_bcd  = r_bcd;
        if (i_cmd.load) begin
            n_mant = i_mantissa[MANTISSA_BITS-1:0];
            n_bcd  = '0;
        end else if (i_cmd.conv) begin
            n_mant = {r_mant[MANTISSA_BITS-2:0], 1'b0};
            n_bcd  = {adj[dva_pkg::BCD_BITS-2:0], r_mant[MANTISSA_BITS-1]};
        end else if (i_cmd.shift) begin
            n_bcd  = {r_bcd[dva_pkg::BCD_BITS-5:0], 4'd0};
        end
    end

    always_comb begin
        unique case (i_cmd.sel)
            dva_pkg::SEL_DIGIT: n_char = dva_pkg::CHAR_ZERO + {3'd0, top};
            dva_pkg::SEL_MINUS: n_char = dva_pkg::CHAR_MINUS;
            dva_pkg::SEL_POINT: n_char = dva_pkg::CHAR_POINT;
            default:            n_char = dva_pkg::CHAR_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mant <= n_mant;
        r_bcd  <= n_bcd;
        if (i_cmd.emit) begin
            r_char <= n_char;
            r_last <= i_cmd.last;
        end
    end

    assign o_char_code = r_char;
    assign o_last      = r_last;
endmodule
`default_nettype wire

FILE: rtl/core/dva_ctrl.sv
// Controller: sequences conversion, leading zero skip and character emission.
`default_nettype none
`include "decimal_value_to_ascii_macros.svh"
module dva_ctrl #(
    parameter int MANTISSA_BITS = 96,
    parameter int MAX_SCALE     = 28
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [dva_pkg::SCALE_W-1:0] i_scale_field,
    input  wire logic                        i_negative,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output dva_pkg::t_cmd                    o_cmd,
    input  wire dva_pkg::t_sts               i_sts
);
    localparam int CNT_W = $clog2(MANTISSA_BITS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_SKIP  = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_INT   = 3'd4;
    localparam logic [2:0] ST_POINT = 3'd5;
    localparam logic [2:0] ST_FRAC  = 3'd6;

    logic [2:0]                r_state;
    logic [2:0]                n_state;
    logic [CNT_W-1:0]          r_cnt;
    logic [CNT_W-1:0]          n_cnt;
    logic [dva_pkg::POS_W-1:0] r_pos;
    logic [dva_pkg::POS_W-1:0] n_pos;
    logic [dva_pkg::POS_W-1:0] r_scale;
    logic [dva_pkg::POS_W-1:0] n_scale;
    logic                      r_neg;
    logic                      n_neg;
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic [dva_pkg::POS_W-1:0] int_digits;
    logic [dva_pkg::POS_W-1:0] pos_inc;
    logic                      out_free;
    logic                      accept;

    assign o_in_stall = (r_state != ST_IDLE) || !i_rst_n;
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign int_digits = dva_pkg::POS_W'(dva_pkg::NUM_DIGITS) - r_scale;
    assign pos_inc    = r_pos + 5'd1;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        n_scale = r_scale;
        n_neg   = r_neg;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = CNT_W'(MANTISSA_BITS);
                    n_neg      = i_negative;
                    n_scale    = (i_scale_field > 8'(MAX_SCALE)) ? '0 : i_scale_field[4:0];
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.conv = 1'b1;
                n_cnt      = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_pos   = '0;
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (pos_inc < int_digits && i_sts.top_zero) begin
                    o_cmd.shift = 1'b1;
                    n_pos       = pos_inc;
                end else begin
                    n_state = r_neg ? ST_SIGN : ST_INT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = dva_pkg::SEL_MINUS;
                    n_state    = ST_INT;
                end
            end
            ST_INT: begin
                if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.sel   = dva_pkg::SEL_DIGIT;
                    o_cmd.shift = 1'b1;
                    n_pos       = pos_inc;
                    if (pos_inc == int_digits) begin
                        if (r_scale != '0) begin
                            n_state = ST_POINT;
                        end else begin
                            o_cmd.last = 1'b1;
                            n_state    = ST_IDLE;
                        end
                    end
                end
            end
            ST_POINT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = dva_pkg::SEL_POINT;
                    n_state    = ST_FRAC;
                end
            end
            ST_FRAC: begin
                if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.sel   = dva_pkg::SEL_DIGIT;
                    o_cmd.shift = 1'b1;
                    n_pos       = pos_inc;
                    if (pos_inc == dva_pkg::POS_W'(dva_pkg::NUM_DIGITS)) begin
                        o_cmd.last = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_cnt   <= n_cnt;
        r_pos   <= n_pos;
        r_scale <= n_scale;
        r_neg   <= n_neg;
    end

    assign o_out_valid = r_out_valid;

    `DVA_ASSERT_SAME(a_emit_free, o_cmd.emit, !r_out_valid || !i_out_stall)
    `DVA_ASSERT_NEXT(a_accept_conv, i_in_valid && !o_in_stall, r_state == ST_CONV)
    `DVA_ASSERT_NEXT(a_last_idle, o_cmd.emit && o_cmd.last, r_state == ST_IDLE && o_out_valid)
    `DVA_ASSERT_SAME(a_scale_range, r_state != ST_IDLE, r_scale <= 5'(MAX_SCALE))
endmodule
`default_nettype wire

FILE: rtl/core/decimal_value_to_ascii.sv
// Top level: formats a scaled 96-bit decimal value as a stream of ASCII characters.
// Sequence: a load, a bit-serial BCD conversion of the mantissa and a leading zero skip,
// then one character per cycle while the output is not stalled (1 to 31 characters).
// A new value is accepted only in the idle state, once the last character of the
// previous value has been emitted.
// Reset: synchronous active low; clears the controller state and the output valid.
`default_nettype none
module decimal_value_to_ascii #(
    parameter int MANTISSA_BITS = 96,
    parameter int MAX_SCALE     = 28
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [63:0] i_mantissa_low,
    input  wire logic [31:0] i_mantissa_high,
    input  wire logic [7:0]  i_scale_field,
    input  wire logic        i_negative,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [6:0]       o_char_code,
    output logic             o_last
);
    dva_pkg::t_cmd cmd;
    dva_pkg::t_sts sts;

    dva_ctrl #(
        .MANTISSA_BITS(MANTISSA_BITS),
        .MAX_SCALE    (MAX_SCALE)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_scale_field(i_scale_field),
        .i_negative   (i_negative),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cmd        (cmd),
        .i_sts        (sts)
    );

    dva_datapath #(
        .MANTISSA_BITS(MANTISSA_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_mantissa ({i_mantissa_high, i_mantissa_low}),
        .o_sts      (sts),
        .o_char_code(o_char_code),
        .o_last     (o_last)
    );
endmodule
`default_nettype wire
